// File: rtl/wti_pkg.sv
// ----------------------------------------------------------------------------
// wti_pkg
// Shared types and constants of the waypoint table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package wti_pkg;

  localparam int ROWS      = 64;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int CNT_W     = ROW_AW + 1;
  localparam int FRAC_BITS = 16;
  localparam int ALPHA_W   = FRAC_BITS + 1;
  localparam int STEP_W    = $clog2(ALPHA_W + 1);
  localparam int COLS      = 5;
  localparam int COL_W     = $clog2(COLS);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_NOT_STARTED = 2'd0,
    STAT_EXPIRED     = 2'd1,
    STAT_VALID       = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_MUL,
    S_DONE
  } state_e;

  typedef enum logic [COL_W-1:0] {
    COL_TIME    = 3'd0,
    COL_X       = 3'd1,
    COL_Y       = 3'd2,
    COL_HEADING = 3'd3,
    COL_SPEED   = 3'd4
  } col_e;

  typedef struct packed {
    logic signed [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] heading;
    logic signed [31:0] speed;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic               op;
    logic [5:0]         row_index;
    logic signed [31:0] row_time;
    logic signed [31:0] row_x;
    logic signed [31:0] row_y;
    logic signed [31:0] row_heading;
    logic signed [31:0] row_speed;
    logic signed [31:0] query_time;
    logic [30:0]        query_span;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [7:0]  before_index;
    logic signed [7:0]  after_index;
    logic signed [31:0] interp_time;
    logic signed [31:0] interp_x;
    logic signed [31:0] interp_y;
    logic signed [31:0] interp_heading;
    logic signed [31:0] interp_speed;
    logic [1:0]         status;
  } rsp_t;

  // Pick one column of a row.
  function automatic logic signed [31:0] col_of(row_t r, logic [COL_W-1:0] c);
    logic signed [31:0] v;
    case (c)
      COL_TIME:    v = r.t;
      COL_X:       v = r.x;
      COL_Y:       v = r.y;
      COL_HEADING: v = r.heading;
      COL_SPEED:   v = r.speed;
      default:     v = r.t;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/wti_req_if.sv
// ----------------------------------------------------------------------------
// wti_req_if
// Request channel: valid/ready handshake with a load or query payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface wti_req_if;
  import wti_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/wti_rsp_if.sv
// ----------------------------------------------------------------------------
// wti_rsp_if
// Result channel: valid/ready handshake with the interpolated row.
// ----------------------------------------------------------------------------
`default_nettype none

interface wti_rsp_if;
  import wti_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/wti_ram.sv
// ----------------------------------------------------------------------------
// wti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/waypoint_table_interpolator_core.sv
// ----------------------------------------------------------------------------
// waypoint_table_interpolator_core
// Waypoint table with piecewise linear interpolation at a query time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake       content
//  req_i     in         valid/ready     load row or query (time, span)
//  rsp_o     out        valid/ready     found, indices, five columns, status
//  cfg       in         cfg_we_i        row_count
//
//  A load writes the row memory.
//  A query scans the table (one memory read per row), runs 17 divider steps,
//  then a multiply and a round-and-add for each of the five columns, and
//  loads the result in done; the next request is taken back in idle.
//  Without a bracketing segment the scan goes straight to done.
//  A query waits in done while the output register holds an unaccepted result.
//  Reset clears control state and row_count; the row memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_table_interpolator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  wti_req_if.sink   req_i,
  wti_rsp_if.source rsp_o
);
  import wti_pkg::*;

  state_e state_q, state_d;

  logic [6:0]         row_count_q;
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               rd_vld_q;
  logic [ROW_AW-1:0]  rd_idx_q;
  logic signed [31:0] t_q;
  logic [30:0]        span_q;
  logic signed [31:0] tmin_q, tmax_q;
  row_t               prev_q, lo_q, hi_q, rd_row;
  logic               fnd_q;
  logic [ROW_AW-1:0]  seg_q;
  logic [33:0]        rem_q;
  logic [32:0]        den_q;
  logic               den_zero_q, num_zero_q, num_eq_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [STEP_W-1:0]  step_q;
  logic [COL_W-1:0]   col_q;
  logic               phase_q;
  logic signed [50:0] prod_q;
  logic signed [31:0] res_q [COLS];
  logic               out_vld_q;
  rsp_t               out_q;

  logic               accept, issue, scan_end, div_end;
  logic [ROW_W-1:0]   rdata;
  logic signed [32:0] num_w, den_w, delta, t_plus;
  logic [33:0]        shifted;
  logic               take;
  logic [ALPHA_W-1:0] alpha_eff;
  logic signed [50:0] rnd;
  logic signed [31:0] col_a;
  logic [7:0]         seg8;
  status_e            stat;

  wti_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_rows (
    .clk_i   (clk_i),
    .we_i    (accept && (req_i.payload.op == OP_LOAD)),
    .waddr_i (req_i.payload.row_index),
    .wdata_i ({req_i.payload.row_time, req_i.payload.row_x, req_i.payload.row_y,
               req_i.payload.row_heading, req_i.payload.row_speed}),
    .raddr_i (cnt_q[ROW_AW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_row  = row_t'(rdata);
  assign accept  = req_i.valid && req_i.ready;
  assign issue   = (state_q == S_SCAN) && (cnt_q < n_q);
  assign num_w   = 33'(t_q) - 33'(lo_q.t);
  assign den_w   = 33'(hi_q.t) - 33'(lo_q.t);
  assign shifted = (step_q == '0) ? rem_q : {rem_q[32:0], 1'b0};
  assign take    = shifted >= {1'b0, den_q};
  assign alpha_eff = den_zero_q ? '0 : alpha_q;
  assign col_a   = col_of(lo_q, col_q);
  assign delta   = 33'(col_of(hi_q, col_q)) - 33'(col_a);
  assign rnd     = prod_q + 51'(1 << (FRAC_BITS - 1));
  assign t_plus  = 33'(t_q) + $signed({2'b00, span_q});
  assign seg8    = {2'b00, seg_q};

  // Next state and handshake
  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    scan_end    = 1'b0;
    div_end     = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid && req_i.payload.op == OP_QUERY) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !rd_vld_q) begin
          scan_end = 1'b1;
          state_d  = fnd_q ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        if (step_q == STEP_W'(ALPHA_W - 1)) begin
          div_end = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (phase_q && col_q == COL_W'(COLS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Status from table extremes
  always_comb begin
    if (n_q == '0 || tmin_q > t_q) stat = STAT_NOT_STARTED;
    else if (33'(tmax_q) <= t_plus) stat = STAT_EXPIRED;
    else stat = STAT_VALID;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_count_q <= '0;
      out_vld_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
      fnd_q       <= 1'b0;
      step_q      <= '0;
      col_q       <= '0;
      phase_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) row_count_q <= cfg_wdata_i;
      rd_vld_q <= issue;
      if (accept) begin
        cnt_q <= '0;
        fnd_q <= 1'b0;
      end
      if (issue) cnt_q <= cnt_q + 1'b1;
      // Take the first bracketing segment only
      if (rd_vld_q && rd_idx_q != '0 && !fnd_q &&
          prev_q.t <= t_q && t_q <= rd_row.t) begin
        fnd_q <= 1'b1;
      end
      if (scan_end) step_q <= '0;
      else if (state_q == S_DIV) step_q <= step_q + 1'b1;
      if (div_end) begin
        col_q   <= '0;
        phase_q <= 1'b0;
      end else if (state_q == S_MUL) begin
        phase_q <= !phase_q;
        if (phase_q) col_q <= col_q + 1'b1;
      end
      if (rsp_o.ready) out_vld_q <= 1'b0;
      if (state_q == S_DONE && (!out_vld_q || rsp_o.ready)) out_vld_q <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q    <= req_i.payload.query_time;
      span_q <= req_i.payload.query_span;
      n_q    <= (row_count_q > 7'(ROWS)) ? CNT_W'(ROWS) : CNT_W'(row_count_q);
    end
    rd_idx_q <= cnt_q[ROW_AW-1:0];
    // Track extremes and remember the previous row
    if (rd_vld_q) begin
      prev_q <= rd_row;
      if (rd_idx_q == '0) begin
        tmin_q <= rd_row.t;
        tmax_q <= rd_row.t;
      end else begin
        if (rd_row.t < tmin_q) tmin_q <= rd_row.t;
        if (rd_row.t > tmax_q) tmax_q <= rd_row.t;
        if (!fnd_q && prev_q.t <= t_q && t_q <= rd_row.t) begin
          lo_q  <= prev_q;
          hi_q  <= rd_row;
          seg_q <= rd_idx_q - 1'b1;
        end
      end
    end
    // Set up the divider
    if (scan_end) begin
      rem_q      <= {1'b0, num_w};
      den_q      <= den_w;
      den_zero_q <= (den_w == '0);
      num_zero_q <= (num_w == '0);
      num_eq_q   <= (num_w == den_w);
    end
    // One restoring step per cycle
    if (state_q == S_DIV) begin
      rem_q   <= take ? shifted - {1'b0, den_q} : shifted;
      alpha_q <= {alpha_q[ALPHA_W-2:0], take};
    end
    // Multiply, then round and add
    if (state_q == S_MUL) begin
      if (!phase_q) prod_q <= $signed({1'b0, alpha_eff}) * delta;
      else res_q[col_q] <= col_a + 32'(rnd >>> FRAC_BITS);
    end
    // Load the output register
    if (state_q == S_DONE && (!out_vld_q || rsp_o.ready)) begin
      out_q.status <= stat;
      out_q.found  <= fnd_q;
      if (fnd_q) begin
        out_q.before_index   <= num_zero_q ? seg8 - 8'd1 : seg8;
        out_q.after_index    <= seg8 + ((!num_zero_q && num_eq_q) ? 8'd2 : 8'd1);
        out_q.interp_time    <= res_q[COL_TIME];
        out_q.interp_x       <= res_q[COL_X];
        out_q.interp_y       <= res_q[COL_Y];
        out_q.interp_heading <= res_q[COL_HEADING];
        out_q.interp_speed   <= res_q[COL_SPEED];
      end else begin
        out_q.before_index   <= '1;
        out_q.after_index    <= '1;
        out_q.interp_time    <= '0;
        out_q.interp_x       <= '0;
        out_q.interp_y       <= '0;
        out_q.interp_heading <= '0;
        out_q.interp_speed   <= '0;
      end
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

endmodule

`default_nettype wire
